@@ hw/rtl/lobl_pkg.sv @@
// Shared types and constants for the order book level block.
package lobl_pkg;

   localparam int ORDER_SLOTS  = 64;
   localparam int PRICE_LEVELS = 64;
   localparam int SLOT_W       = $clog2(ORDER_SLOTS);
   localparam int LVL_W        = $clog2(PRICE_LEVELS);
   localparam int CNT_W        =
      $clog2(((ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS) + 1);
   localparam int TOTAL_W      = 38;
   localparam int WORD_W       = 32;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_MODIFY = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_ZERO_QTY  = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_RANGE     = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_SCAN,
      BS_TREAD,
      BS_TCALC,
      BS_LSCAN,
      BS_RESP
   } bstate_type;

   // classified request handed from front to back
   typedef struct packed {
      kind_type            kind;
      logic [WORD_W-1:0]   order_id;
      logic [WORD_W-1:0]   quantity;
      logic                is_buy;
      logic [LVL_W-1:0]    level;
      logic                in_range;
      logic                qty_zero;
   } cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0]   order_id;
      logic [LVL_W-1:0]    level;
      logic [WORD_W-1:0]   quantity;
      logic                is_buy;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

endpackage

@@ hw/rtl/lobl_if.sv @@
// Channel interfaces: request, response and register write.
interface lobl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] order_id;
   logic [31:0] price;
   logic [31:0] quantity;
   logic        is_buy;
   modport source (output valid, kind, order_id, price, quantity, is_buy, input ready);
   modport sink   (input valid, kind, order_id, price, quantity, is_buy, output ready);
endinterface

interface lobl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [37:0] level_total;
   logic [31:0] bid_price;
   logic        bid_present;
   logic [31:0] ask_price;
   logic        ask_present;
   modport source (output valid, status, level_total, bid_price, bid_present, ask_price,
                   ask_present, input ready);
   modport sink   (input valid, status, level_total, bid_price, bid_present, ask_price,
                   ask_present, output ready);
endinterface

interface lobl_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/lobl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lobl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hw/rtl/lobl_front.sv @@
// Front end: accepts requests, maps price to level and queues them.
module lobl_front (
   input  logic                  clock,
   input  logic                  reset,
   lobl_req_if.sink              req,
   input  logic [31:0]           base,
   output logic                  cmd_valid,
   output lobl_pkg::cmd_type     cmd,
   input  logic                  cmd_pop
);
   lobl_pkg::cmd_type                q_ff [lobl_pkg::QUEUE_DEPTH];
   logic [lobl_pkg::QPTR_W-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [lobl_pkg::QPTR_W:0]        cnt_ff, cnt_in;
   lobl_pkg::cmd_type                new_cmd;
   logic [31:0]                      diff;
   logic                             push;

   assign req.ready = (cnt_ff < (lobl_pkg::QPTR_W+1)'(lobl_pkg::QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign diff      = req.price - base;

   always_comb begin
      new_cmd.kind     = lobl_pkg::kind_type'(req.kind);
      new_cmd.order_id = req.order_id;
      new_cmd.quantity = req.quantity;
      new_cmd.is_buy   = req.is_buy;
      new_cmd.level    = diff[lobl_pkg::LVL_W-1:0];
      new_cmd.in_range = (diff < 32'(lobl_pkg::PRICE_LEVELS));
      new_cmd.qty_zero = (req.quantity == '0);
   end

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = cmd_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (lobl_pkg::QPTR_W+1)'(push) - (lobl_pkg::QPTR_W+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= new_cmd;
      end
   end

   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];
endmodule

@@ hw/rtl/lobl_back.sv @@
// Back end: order slot table, level totals and best price tracking.
module lobl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           base,
   input  logic                  cmd_valid,
   input  lobl_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   lobl_rsp_if.source            rsp
);
   localparam int SW = lobl_pkg::SLOT_W;
   localparam int LW = lobl_pkg::LVL_W;
   localparam int CW = lobl_pkg::CNT_W;
   localparam int TW = lobl_pkg::TOTAL_W;

   lobl_pkg::bstate_type       state_ff, state_in;
   lobl_pkg::cmd_type          cur_ff, cur_in;
   lobl_pkg::slot_type         ent_ff, ent_in, slot_q, slot_wd;
   lobl_pkg::status_type       stat_ff, stat_in;
   logic [LW-1:0]              lvl_ff, lvl_in;
   logic [SW-1:0]              slot_ff, slot_in;
   logic                       side_ff, side_in;
   logic [CW-1:0]              cnt_ff, cnt_in, ridx_ff, ridx_in;
   logic                       rvld_ff, rvld_in;
   logic [lobl_pkg::ORDER_SLOTS-1:0]  svld_ff, svld_in;
   logic [lobl_pkg::PRICE_LEVELS-1:0] bvld_ff, bvld_in, avld_ff, avld_in;
   logic [LW-1:0]              bid_ff, bid_in, ask_ff, ask_in;
   logic                       bidp_ff, bidp_in, askp_ff, askp_in;
   logic [TW-1:0]              tot_ff, tot_in;
   logic [TW-1:0]              buy_q, sell_q, old_tot, new_tot, buy_t, sell_t;
   logic                       slot_we, buy_we, sell_we, hit, issue;
   logic [SW-1:0]              slot_ra;
   logic [LW-1:0]              tot_ra, ridx_l;

   assign ridx_l = ridx_ff[LW-1:0];
   assign slot_ra = cnt_ff[SW-1:0];
   assign tot_ra  = (state_ff == lobl_pkg::BS_LSCAN) ? cnt_ff[LW-1:0] : lvl_ff;

   lobl_ram #(.WIDTH(lobl_pkg::SLOT_BITS), .DEPTH(lobl_pkg::ORDER_SLOTS)) u_slot_ram (
      .clock(clock), .we(slot_we), .waddr(slot_ff), .wdata(slot_wd),
      .raddr(slot_ra), .rdata(slot_q));
   lobl_ram #(.WIDTH(TW), .DEPTH(lobl_pkg::PRICE_LEVELS)) u_buy_ram (
      .clock(clock), .we(buy_we), .waddr(lvl_ff), .wdata(new_tot),
      .raddr(tot_ra), .rdata(buy_q));
   lobl_ram #(.WIDTH(TW), .DEPTH(lobl_pkg::PRICE_LEVELS)) u_sell_ram (
      .clock(clock), .we(sell_we), .waddr(lvl_ff), .wdata(new_tot),
      .raddr(tot_ra), .rdata(sell_q));

   // unwritten levels read as zero
   always_comb begin
      if (state_ff == lobl_pkg::BS_LSCAN) begin
         buy_t  = bvld_ff[ridx_l] ? buy_q : '0;
         sell_t = avld_ff[ridx_l] ? sell_q : '0;
      end else begin
         buy_t  = bvld_ff[lvl_ff] ? buy_q : '0;
         sell_t = avld_ff[lvl_ff] ? sell_q : '0;
      end
   end

   assign old_tot = side_ff ? buy_t : sell_t;

   always_comb begin
      case (cur_ff.kind)
         lobl_pkg::KIND_ADD:    new_tot = old_tot + TW'(cur_ff.quantity);
         lobl_pkg::KIND_CANCEL: new_tot = old_tot - TW'(ent_ff.quantity);
         lobl_pkg::KIND_MODIFY: new_tot = old_tot - TW'(ent_ff.quantity)
                                          + TW'(cur_ff.quantity);
         default:               new_tot = old_tot;
      endcase
   end

   always_comb begin
      if (cur_ff.kind == lobl_pkg::KIND_ADD) begin
         hit = rvld_ff && !svld_ff[ridx_ff[SW-1:0]];
      end else begin
         hit = rvld_ff && svld_ff[ridx_ff[SW-1:0]] && (slot_q.order_id == cur_ff.order_id);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lobl_pkg::BS_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  lobl_pkg::KIND_ADD:
                     state_in = (cmd.qty_zero || !cmd.in_range) ? lobl_pkg::BS_RESP
                                                                : lobl_pkg::BS_SCAN;
                  lobl_pkg::KIND_CANCEL: state_in = lobl_pkg::BS_SCAN;
                  lobl_pkg::KIND_MODIFY:
                     state_in = cmd.qty_zero ? lobl_pkg::BS_RESP : lobl_pkg::BS_SCAN;
                  default:
                     state_in = cmd.in_range ? lobl_pkg::BS_TREAD : lobl_pkg::BS_RESP;
               endcase
            end
         end
         lobl_pkg::BS_SCAN: begin
            if (hit) begin
               state_in = lobl_pkg::BS_TREAD;
            end else if (!rvld_ff && cnt_ff == CW'(lobl_pkg::ORDER_SLOTS)) begin
               state_in = lobl_pkg::BS_RESP;
            end
         end
         lobl_pkg::BS_TREAD: state_in = lobl_pkg::BS_TCALC;
         lobl_pkg::BS_TCALC:
            state_in = (cur_ff.kind == lobl_pkg::KIND_CANCEL) ? lobl_pkg::BS_LSCAN
                                                              : lobl_pkg::BS_RESP;
         lobl_pkg::BS_LSCAN: begin
            if (!rvld_ff && cnt_ff == CW'(lobl_pkg::PRICE_LEVELS)) begin
               state_in = lobl_pkg::BS_RESP;
            end
         end
         lobl_pkg::BS_RESP: begin
            if (rsp.ready) begin
               state_in = lobl_pkg::BS_IDLE;
            end
         end
         default: state_in = lobl_pkg::BS_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_in  = cur_ff;
      ent_in  = ent_ff;
      stat_in = stat_ff;
      lvl_in  = lvl_ff;
      slot_in = slot_ff;
      side_in = side_ff;
      cnt_in  = cnt_ff;
      ridx_in = ridx_ff;
      rvld_in = 1'b0;
      svld_in = svld_ff;
      bvld_in = bvld_ff;
      avld_in = avld_ff;
      bid_in  = bid_ff;
      bidp_in = bidp_ff;
      ask_in  = ask_ff;
      askp_in = askp_ff;
      tot_in  = tot_ff;
      cmd_pop = 1'b0;
      slot_we = 1'b0;
      buy_we  = 1'b0;
      sell_we = 1'b0;
      slot_wd = ent_ff;
      issue   = 1'b0;
      case (state_ff)
         lobl_pkg::BS_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               lvl_in  = cmd.level;
               side_in = cmd.is_buy;
               cnt_in  = '0;
               tot_in  = '0;
               stat_in = lobl_pkg::STAT_OK;
               if ((cmd.kind == lobl_pkg::KIND_ADD || cmd.kind == lobl_pkg::KIND_MODIFY)
                   && cmd.qty_zero) begin
                  stat_in = lobl_pkg::STAT_ZERO_QTY;
               end else if ((cmd.kind == lobl_pkg::KIND_ADD ||
                             cmd.kind == lobl_pkg::KIND_QUERY) && !cmd.in_range) begin
                  stat_in = lobl_pkg::STAT_RANGE;
               end
            end
         end
         lobl_pkg::BS_SCAN: begin
            issue   = (cnt_ff < CW'(lobl_pkg::ORDER_SLOTS)) && !hit;
            rvld_in = issue;
            ridx_in = cnt_ff;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (hit) begin
               slot_in = ridx_ff[SW-1:0];
               if (cur_ff.kind != lobl_pkg::KIND_ADD) begin
                  ent_in  = slot_q;
                  lvl_in  = slot_q.level;
                  side_in = slot_q.is_buy;
               end
            end else if (!rvld_ff && cnt_ff == CW'(lobl_pkg::ORDER_SLOTS)) begin
               stat_in = (cur_ff.kind == lobl_pkg::KIND_ADD) ? lobl_pkg::STAT_FULL
                                                            : lobl_pkg::STAT_NOT_FOUND;
            end
         end
         lobl_pkg::BS_TCALC: begin
            tot_in = new_tot;
            if (cur_ff.kind != lobl_pkg::KIND_QUERY) begin
               buy_we  = side_ff;
               sell_we = !side_ff;
               if (side_ff) begin
                  bvld_in[lvl_ff] = 1'b1;
               end else begin
                  avld_in[lvl_ff] = 1'b1;
               end
            end
            case (cur_ff.kind)
               lobl_pkg::KIND_ADD: begin
                  slot_we          = 1'b1;
                  slot_wd.order_id = cur_ff.order_id;
                  slot_wd.level    = lvl_ff;
                  slot_wd.quantity = cur_ff.quantity;
                  slot_wd.is_buy   = side_ff;
                  svld_in[slot_ff] = 1'b1;
                  if (side_ff && (!bidp_ff || lvl_ff > bid_ff)) begin
                     bidp_in = 1'b1;
                     bid_in  = lvl_ff;
                  end
                  if (!side_ff && (!askp_ff || lvl_ff < ask_ff)) begin
                     askp_in = 1'b1;
                     ask_in  = lvl_ff;
                  end
               end
               lobl_pkg::KIND_CANCEL: begin
                  svld_in[slot_ff] = 1'b0;
                  cnt_in  = '0;
                  bidp_in = 1'b0;
                  bid_in  = '0;
                  askp_in = 1'b0;
                  ask_in  = '0;
               end
               lobl_pkg::KIND_MODIFY: begin
                  slot_we          = 1'b1;
                  slot_wd.quantity = cur_ff.quantity;
               end
               default: ;
            endcase
         end
         lobl_pkg::BS_LSCAN: begin
            issue   = (cnt_ff < CW'(lobl_pkg::PRICE_LEVELS));
            rvld_in = issue;
            ridx_in = cnt_ff;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (rvld_ff) begin
               // ascending scan: last nonzero buy level wins, first nonzero sell level
               if (buy_t != '0) begin
                  bidp_in = 1'b1;
                  bid_in  = ridx_l;
               end
               if (sell_t != '0 && !askp_ff) begin
                  askp_in = 1'b1;
                  ask_in  = ridx_l;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lobl_pkg::BS_IDLE;
         rvld_ff  <= 1'b0;
         svld_ff  <= '0;
         bvld_ff  <= '0;
         avld_ff  <= '0;
         bid_ff   <= '0;
         bidp_ff  <= 1'b0;
         ask_ff   <= '0;
         askp_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rvld_ff  <= rvld_in;
         svld_ff  <= svld_in;
         bvld_ff  <= bvld_in;
         avld_ff  <= avld_in;
         bid_ff   <= bid_in;
         bidp_ff  <= bidp_in;
         ask_ff   <= ask_in;
         askp_ff  <= askp_in;
         cnt_ff   <= cnt_in;
      end
      cur_ff  <= cur_in;
      ent_ff  <= ent_in;
      stat_ff <= stat_in;
      lvl_ff  <= lvl_in;
      slot_ff <= slot_in;
      side_ff <= side_in;
      ridx_ff <= ridx_in;
      tot_ff  <= tot_in;
   end

   assign rsp.valid       = (state_ff == lobl_pkg::BS_RESP);
   assign rsp.status      = stat_ff;
   assign rsp.level_total = tot_ff;
   assign rsp.bid_present = bidp_ff;
   assign rsp.ask_present = askp_ff;
   assign rsp.bid_price   = bidp_ff ? base + 32'(bid_ff) : '0;
   assign rsp.ask_price   = askp_ff ? base + 32'(ask_ff) : '0;
endmodule

@@ hw/rtl/limit_order_book_levels.sv @@
// Top level of the limit order book price level block.
// Keeps up to 64 resting orders and per-side totals for 64 price levels
// starting at price_base (csr write). Each request adds, cancels, modifies
// or queries and yields exactly one response. Requests queue two deep in
// the front end, so a new request is taken while a response waits. The
// back end scans one slot or level per cycle over the slot RAM and
// level RAMs: a request rejected on its fields skips the scans; a query
// reads its level total directly; add searches the 64 valid bits for a
// free slot; modify searches by id; cancel searches by id, then walks
// the 64 levels to rebuild best bid/ask. No clearing pass is needed
// after reset: valid bits mark live slots and written levels.
module limit_order_book_levels (
   input  logic        clock,
   input  logic        reset,
   lobl_req_if.sink    req_ch,
   lobl_rsp_if.source  rsp_ch,
   lobl_csr_if.sink    csr_ch
);
   logic [31:0]        base_ff, base_in;
   logic               cmd_valid, cmd_pop;
   lobl_pkg::cmd_type  cmd;

   // price_base register; the user must write it only while idle; the block itself does not enforce this
   assign csr_ch.ready = 1'b1;
   assign base_in      = (csr_ch.valid) ? csr_ch.data : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   lobl_front u_front (
      .clock(clock), .reset(reset), .req(req_ch), .base(base_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

   lobl_back u_back (
      .clock(clock), .reset(reset), .base(base_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .rsp(rsp_ch));
endmodule

@@ hw/rtl/lobl_chk.sv @@
// Port-level checks for the order book level block, bound to the top.
module lobl_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [37:0] rsp_total,
   input logic [31:0] rsp_bid,
   input logic        rsp_bid_p,
   input logic [31:0] rsp_ask,
   input logic        rsp_ask_p
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reject_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lobl_pkg::STAT_OK |-> rsp_total == '0)
      else $error("rejected request carries a total");

   a_bid_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bid_p |-> rsp_bid == '0)
      else $error("best bid without bid present");

   a_ask_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ask_p |-> rsp_ask == '0)
      else $error("best ask without ask present");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");
endmodule

bind limit_order_book_levels lobl_chk u_lobl_chk (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_status(rsp_ch.status), .rsp_total(rsp_ch.level_total),
   .rsp_bid(rsp_ch.bid_price), .rsp_bid_p(rsp_ch.bid_present),
   .rsp_ask(rsp_ch.ask_price), .rsp_ask_p(rsp_ch.ask_present));

@@ dv/lobl_tb_pkg.sv @@
`timescale 1ns / 1ps
// Request and response record types used by the order book level testbench.
package lobl_tb_pkg;
   import lobl_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] order_id;
      logic [31:0] price;
      logic [31:0] quantity;
      logic        is_buy;
   } book_req_type;

   typedef struct packed {
      status_type  status;
      logic [37:0] level_total;
      logic [31:0] bid_price;
      logic        bid_present;
      logic [31:0] ask_price;
      logic        ask_present;
   } book_rsp_type;
endpackage

@@ dv/lobl_book_checker.sv @@
`timescale 1ns / 1ps
// Checker: mirrors the order book, predicts each response and compares it.
module lobl_book_checker
   import lobl_pkg::*;
   import lobl_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lobl_req_if        req_ch,
   lobl_rsp_if        rsp_ch,
   lobl_csr_if        csr_ch,
   output int         fail_count,
   output int         pending_count
);
   logic [31:0] base_price;
   logic        live     [ORDER_SLOTS];
   logic [31:0] live_id  [ORDER_SLOTS];
   logic [5:0]  live_lvl [ORDER_SLOTS];
   logic [31:0] live_qty [ORDER_SLOTS];
   logic        live_buy [ORDER_SLOTS];
   logic [37:0] bid_sum  [PRICE_LEVELS];
   logic [37:0] ask_sum  [PRICE_LEVELS];
   logic [5:0]  bid_lvl, ask_lvl;
   logic        has_bid, has_ask;
   book_rsp_type expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic int find_order(logic [31:0] id);
      for (int i = 0; i < ORDER_SLOTS; i++)
         if (live[i] && live_id[i] == id) return i;
      return -1;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic predict_book(book_req_type r);
      book_rsp_type p;
      logic [31:0]  d;
      int           s;
      p = '0;
      p.status = STAT_OK;
      case (r.kind)
         KIND_ADD: begin
            d = r.price - base_price;
            s = -1;
            for (int i = ORDER_SLOTS - 1; i >= 0; i--) if (!live[i]) s = i;
            if (r.quantity == 0) p.status = STAT_ZERO_QTY;
            else if (d >= PRICE_LEVELS) p.status = STAT_RANGE;
            else if (s < 0) p.status = STAT_FULL;
            else begin
               live[s] = 1; live_id[s] = r.order_id; live_lvl[s] = d[5:0];
               live_qty[s] = r.quantity; live_buy[s] = r.is_buy;
               if (r.is_buy) begin
                  bid_sum[d[5:0]] += 38'(r.quantity); p.level_total = bid_sum[d[5:0]];
                  if (!has_bid || d[5:0] > bid_lvl) begin has_bid = 1; bid_lvl = d[5:0]; end
               end else begin
                  ask_sum[d[5:0]] += 38'(r.quantity); p.level_total = ask_sum[d[5:0]];
                  if (!has_ask || d[5:0] < ask_lvl) begin has_ask = 1; ask_lvl = d[5:0]; end
               end
            end
         end
         KIND_CANCEL: begin
            s = find_order(r.order_id);
            if (s < 0) p.status = STAT_NOT_FOUND;
            else begin
               if (live_buy[s]) begin
                  bid_sum[live_lvl[s]] -= 38'(live_qty[s]);
                  p.level_total = bid_sum[live_lvl[s]];
               end else begin
                  ask_sum[live_lvl[s]] -= 38'(live_qty[s]);
                  p.level_total = ask_sum[live_lvl[s]];
               end
               live[s] = 0;
               // full rescan of both sides
               has_bid = 0; bid_lvl = 0; has_ask = 0; ask_lvl = 0;
               for (int i = 0; i < PRICE_LEVELS; i++)
                  if (bid_sum[i] != 0) begin has_bid = 1; bid_lvl = 6'(i); end
               for (int i = PRICE_LEVELS - 1; i >= 0; i--)
                  if (ask_sum[i] != 0) begin has_ask = 1; ask_lvl = 6'(i); end
            end
         end
         KIND_MODIFY: begin
            s = find_order(r.order_id);
            if (r.quantity == 0) p.status = STAT_ZERO_QTY;
            else if (s < 0) p.status = STAT_NOT_FOUND;
            else if (live_buy[s]) begin
               bid_sum[live_lvl[s]] = bid_sum[live_lvl[s]] - 38'(live_qty[s])
                                      + 38'(r.quantity);
               p.level_total = bid_sum[live_lvl[s]];
               live_qty[s] = r.quantity;
            end else begin
               ask_sum[live_lvl[s]] = ask_sum[live_lvl[s]] - 38'(live_qty[s])
                                      + 38'(r.quantity);
               p.level_total = ask_sum[live_lvl[s]];
               live_qty[s] = r.quantity;
            end
         end
         default: begin
            d = r.price - base_price;
            if (d >= PRICE_LEVELS) p.status = STAT_RANGE;
            else p.level_total = r.is_buy ? bid_sum[d[5:0]] : ask_sum[d[5:0]];
         end
      endcase
      p.bid_present = has_bid;
      p.ask_present = has_ask;
      p.bid_price = has_bid ? base_price + 32'(bid_lvl) : '0;
      p.ask_price = has_ask ? base_price + 32'(ask_lvl) : '0;
      expected_rsps.push_back(p);
   endtask

   task automatic compare_rsp();
      book_rsp_type w;
      if (expected_rsps.size() == 0) begin
         report_mismatch("unexpected response", 0, 0);
         return;
      end
      w = expected_rsps.pop_front();
      if (rsp_ch.status !== w.status) report_mismatch("status", rsp_ch.status, w.status);
      if (rsp_ch.level_total !== w.level_total)
         report_mismatch("level_total", rsp_ch.level_total, w.level_total);
      if (rsp_ch.bid_price !== w.bid_price)
         report_mismatch("bid_price", rsp_ch.bid_price, w.bid_price);
      if (rsp_ch.bid_present !== w.bid_present)
         report_mismatch("bid_present", rsp_ch.bid_present, w.bid_present);
      if (rsp_ch.ask_price !== w.ask_price)
         report_mismatch("ask_price", rsp_ch.ask_price, w.ask_price);
      if (rsp_ch.ask_present !== w.ask_present)
         report_mismatch("ask_present", rsp_ch.ask_present, w.ask_present);
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         base_price = '0; has_bid = 0; has_ask = 0; bid_lvl = 0; ask_lvl = 0;
         for (int i = 0; i < ORDER_SLOTS; i++) live[i] = 0;
         for (int i = 0; i < PRICE_LEVELS; i++) begin bid_sum[i] = '0; ask_sum[i] = '0; end
      end else begin
         // response first: it belongs to an earlier request
         if (rsp_ch.valid && rsp_ch.ready) compare_rsp();
         if (csr_ch.valid && csr_ch.ready) base_price = csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            predict_book({kind_type'(req_ch.kind), req_ch.order_id, req_ch.price,
                          req_ch.quantity, req_ch.is_buy});
      end
   end
endmodule

@@ dv/limit_order_book_levels_tb.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
module limit_order_book_levels_tb;
   import lobl_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending_count;
   int   send_idle_pct, recv_idle_pct;
   int   cycle_count = 0;
   logic [31:0] base_now = 0;
   logic [31:0] id_pool [8];

   lobl_req_if req_ch();
   lobl_rsp_if rsp_ch();
   lobl_csr_if csr_ch();

   limit_order_book_levels dut (.clock(clock), .reset(reset),
      .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch));

   lobl_book_checker checker_i (.clock(clock), .reset(reset), .req_ch(req_ch),
      .rsp_ch(rsp_ch), .csr_ch(csr_ch), .fail_count(fail_count),
      .pending_count(pending_count));

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Watchdog: a worst-case cancel (id search, then level walk) is the longest request, stalls stretch it.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("limit_order_book_levels_tb: FAIL");
         $finish;
      end
   end

   // Receiver: random backpressure, changes on the falling edge.
   always @(negedge clock)
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);

   // Drive one request; waits for the handshake, random gaps before it.
   // valid stays up after the handshake; the next gap or drain drops it.
   task automatic send_req(kind_type k, logic [31:0] id, logic [31:0] pr,
                           logic [31:0] q, logic b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid    <= 1;
      req_ch.kind     <= k;
      req_ch.order_id <= id;
      req_ch.price    <= pr;
      req_ch.quantity <= q;
      req_ch.is_buy   <= b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Wait for all responses, then let the block's tail settle.
   task automatic drain();
      req_ch.valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_base(logic [31:0] v);
      csr_ch.valid <= 1;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 0;
      base_now = v;
   endtask

   // Mostly well-formed: prices near the base, ids from a small pool so
   // cancels and modifies hit live orders; some noise across the full range.
   task automatic random_req();
      kind_type    k;
      logic [31:0] id, pr, q;
      k  = kind_type'($urandom_range(3));
      id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(7)];
      case ($urandom_range(9))
         0:       pr = $urandom;
         1:       pr = base_now + 64 + $urandom_range(3);
         2:       pr = base_now - 1 - $urandom_range(3);
         default: pr = base_now + $urandom_range(63);
      endcase
      case ($urandom_range(9))
         0:       q = 0;
         1:       q = $urandom;
         2:       q = 32'hFFFF_FFFF;
         default: q = $urandom_range(1000, 1);
      endcase
      send_req(k, id, pr, q, 1'($urandom_range(1)));
   endtask

   initial begin
      req_ch.valid = 0; req_ch.kind = KIND_ADD; req_ch.order_id = 0;
      req_ch.price = 0; req_ch.quantity = 0; req_ch.is_buy = 0;
      csr_ch.valid = 0; csr_ch.data = 0;
      send_idle_pct = 33; recv_idle_pct = 46;
      for (int i = 0; i < 8; i++) id_pool[i] = (i == 7) ? 32'hFFFF_FFFF : i * 3;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: edges of each field, every kind, each corner
      send_req(KIND_QUERY,  0, 0, 0, 1);              // empty book
      send_req(KIND_ADD,    1, 5, 0, 1);              // zero qty
      send_req(KIND_ADD,    1, 64, 0, 0);
      send_req(KIND_ADD,    1, 64, 7, 0);             // out of range
      send_req(KIND_ADD,    32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, 1);
      send_req(KIND_ADD,    2, 0, 32'hFFFF_FFFF, 1);
      send_req(KIND_ADD,    2, 10, 5, 0);             // duplicate id
      send_req(KIND_ADD,    3, 0, 1, 0);
      send_req(KIND_QUERY,  0, 63, 0, 1);
      send_req(KIND_QUERY,  0, 32'hFFFF_FFFF, 0, 0);
      send_req(KIND_MODIFY, 2, 0, 0, 0);              // zero qty
      send_req(KIND_MODIFY, 99, 0, 4, 0);             // unknown id
      send_req(KIND_MODIFY, 2, 0, 9, 0);              // lowest slot with id
      send_req(KIND_CANCEL, 99, 0, 0, 0);
      send_req(KIND_CANCEL, 32'hFFFF_FFFF, 0, 0, 0);  // rescan best bid
      send_req(KIND_CANCEL, 3, 0, 0, 1);              // rescan best ask
      for (int i = 0; i < 65; i++)                     // fill, then table full
         send_req(KIND_ADD, 1000 + i, i % 64, i + 1, i[0]);
      for (int i = 0; i < 64; i++) send_req(KIND_CANCEL, 1000 + i, 0, 0, 0);
      drain();

      // base change while orders rest; then high base wrapping around
      write_base(32'hFFFF_FFE0);
      send_req(KIND_ADD, 5, 32'hFFFF_FFE0, 3, 1);
      send_req(KIND_ADD, 6, 32'h0000_001F, 4, 0);     // level 63 via wrap
      send_req(KIND_QUERY, 0, 32'h0000_001F, 0, 0);
      drain();                                        // pause until all back

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin send_idle_pct = 46; recv_idle_pct = 33; end
         if (phase == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         case (phase)
            0: write_base(32'd0);
            1: write_base(32'hFFFF_FFFF);
            2: write_base(32'd1000);
            3: write_base(32'hFFFF_FFC0);
            4: write_base($urandom);
            default: write_base(32'h8000_0000);
         endcase
         for (int i = 0; i < 8; i++) id_pool[i] = (i == 7) ? $urandom : i;
         for (int n = 0; n < 192; n++) random_req();
         drain();
      end

      if (fail_count == 0) $display("limit_order_book_levels_tb: PASS");
      else $display("limit_order_book_levels_tb: FAIL");
      $finish;
   end
endmodule
